### src/tsdw_pkg.sv
// Package: calendar constants, lane result type and date helper functions.
package tsdw_pkg;

   localparam int YearMax   = 9999;
   localparam int RefDay    = 3;
   localparam int RefMonth  = 10;
   localparam int RefYear   = 2022;
   localparam int DaysYear  = 365;
   localparam int DaysLeap  = 366;

   localparam int DayW      = 22;
   localparam int WdSumW    = 15;

   // Registered per-timestamp result of one lane.
   typedef struct packed {
      logic            valid;
      logic [DayW-1:0] days;
      logic [4:0]      hour;
      logic [5:0]      minute;
      logic [5:0]      second;
      logic [2:0]      weekday;
   } lane_out_type;

   // Days in month; February follows the every-fourth-year rule.
   function automatic logic [4:0] month_len(input logic [3:0] mo, input logic leap);
      logic [4:0] len;
      begin
         case (mo)
            4'd2:                          len = leap ? 5'd29 : 5'd28;
            4'd4, 4'd6, 4'd9, 4'd11:       len = 5'd30;
            default:                       len = 5'd31;
         endcase
         return len;
      end
   endfunction

   // Days before the first of the month.
   function automatic logic [8:0] month_offset(input logic [3:0] mo, input logic leap);
      logic [8:0] off;
      logic [8:0] lp;
      begin
         lp = {8'd0, leap};
         case (mo)
            4'd1:    off = 9'd0;
            4'd2:    off = 9'd31;
            4'd3:    off = 9'd59  + lp;
            4'd4:    off = 9'd90  + lp;
            4'd5:    off = 9'd120 + lp;
            4'd6:    off = 9'd151 + lp;
            4'd7:    off = 9'd181 + lp;
            4'd8:    off = 9'd212 + lp;
            4'd9:    off = 9'd243 + lp;
            4'd10:   off = 9'd273 + lp;
            4'd11:   off = 9'd304 + lp;
            4'd12:   off = 9'd334 + lp;
            default: off = 9'd0;
         endcase
         return off;
      end
   endfunction

   // Residue mod 7 by folding octal digits (8 is 1 mod 7).
   function automatic logic [2:0] mod7(input logic [WdSumW-1:0] x);
      logic [5:0] s1;
      logic [3:0] s2;
      begin
         s1 = 6'(x[2:0]) + 6'(x[5:3]) + 6'(x[8:6]) + 6'(x[11:9]) + 6'(x[14:12]);
         s2 = 4'(s1[2:0]) + 4'(s1[5:3]);
         return (s2 >= 4'd7) ? 3'(s2 - 4'd7) : s2[2:0];
      end
   endfunction

   localparam int RefDays = (RefYear - 1) * DaysYear + (RefYear - 1) / 4
                            + int'(month_offset(4'(RefMonth), (RefYear % 4) == 0))
                            + RefDay - 1;
   localparam int RefMod7 = RefDays % 7;
   // Day minus one, plus a full week, minus the reference residue.
   localparam int WdBias  = 6 - RefMod7;

endpackage

### src/tsdw_lane.sv
// Lane: range check, day number and weekday residue of one timestamp.
module tsdw_lane
   import tsdw_pkg::*;
(
   input  logic         clock,
   input  logic [4:0]   day,
   input  logic [3:0]   month,
   input  logic [13:0]  year,
   input  logic [4:0]   hour,
   input  logic [5:0]   minute,
   input  logic [5:0]   second,
   output lane_out_type lane_out
);

   logic              leap;
   logic [13:0]       yless;
   logic [8:0]        moff;
   logic              ok;
   logic [DayW-1:0]   days;
   logic [WdSumW-1:0] wd_sum;
   lane_out_type      out_ff;
   lane_out_type      out_in;

   assign leap  = (year[1:0] == 2'b00);
   assign yless = year - 14'd1;
   assign moff  = month_offset(month, leap);

   assign ok = (year >= 14'd1) && (year <= 14'(YearMax))
            && (month >= 4'd1) && (month <= 4'd12)
            && (day >= 5'd1) && (day <= month_len(month, leap))
            && (hour < 5'd24) && (minute < 6'd60) && (second < 6'd60);

   assign days = DayW'(yless) * DayW'(DaysYear) + DayW'(yless >> 2)
               + DayW'(moff) + DayW'(day) - DayW'(1);

   // 365 is 1 mod 7, so whole years contribute their count.
   assign wd_sum = WdSumW'(yless) + WdSumW'(yless >> 2) + WdSumW'(moff)
                 + WdSumW'(day) + WdSumW'(WdBias);

   always_comb begin
      out_in.valid   = ok;
      out_in.days    = days;
      out_in.hour    = hour;
      out_in.minute  = minute;
      out_in.second  = second;
      out_in.weekday = mod7(wd_sum);
   end

   always_ff @(posedge clock) begin
      out_ff <= out_in;
   end

   assign lane_out = out_ff;

endmodule

### src/tsdw_merge.sv
// Merge: order the two lanes, subtract with mixed-radix borrows, gate by validity.
module tsdw_merge
   import tsdw_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            lane_vld,
   input  lane_out_type    lane_a,
   input  lane_out_type    lane_b,
   output logic            strobe,
   output logic            first_valid,
   output logic            other_valid,
   output logic            first_not_earlier,
   output logic [DayW-1:0] diff_days,
   output logic [4:0]      diff_hours,
   output logic [5:0]      diff_minutes,
   output logic [5:0]      diff_seconds,
   output logic [2:0]      first_weekday
);

   logic            both;
   logic            a_ge;
   lane_out_type    hi;
   lane_out_type    lo;
   logic [6:0]      ts;
   logic [6:0]      tm;
   logic [5:0]      th;
   logic            bs;
   logic            bm;
   logic            bh;
   logic [5:0]      ds;
   logic [5:0]      dm;
   logic [4:0]      dh;
   logic [DayW-1:0] dd;

   logic            strobe_ff, strobe_in;
   logic            fv_ff, ov_ff, ne_ff;
   logic [DayW-1:0] dd_ff;
   logic [4:0]      dh_ff;
   logic [5:0]      dm_ff, ds_ff;
   logic [2:0]      wd_ff;

   assign both = lane_a.valid && lane_b.valid;
   assign a_ge = (lane_a.days > lane_b.days)
              || ((lane_a.days == lane_b.days)
                  && ({lane_a.hour, lane_a.minute, lane_a.second}
                      >= {lane_b.hour, lane_b.minute, lane_b.second}));
   assign hi = a_ge ? lane_a : lane_b;
   assign lo = a_ge ? lane_b : lane_a;

   always_comb begin
      ts = {1'b0, hi.second} - {1'b0, lo.second};
      bs = ts[6];
      ds = bs ? 6'(ts + 7'd60) : ts[5:0];
      tm = {1'b0, hi.minute} - {1'b0, lo.minute} - 7'(bs);
      bm = tm[6];
      dm = bm ? 6'(tm + 7'd60) : tm[5:0];
      th = {1'b0, hi.hour} - {1'b0, lo.hour} - 6'(bm);
      bh = th[5];
      dh = bh ? 5'(th + 6'd24) : th[4:0];
      dd = hi.days - lo.days - DayW'(bh);
   end

   assign strobe_in = lane_vld;

   always_ff @(posedge clock) begin
      if (reset) begin
         strobe_ff <= 1'b0;
      end else begin
         strobe_ff <= strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      fv_ff <= lane_a.valid;
      ov_ff <= lane_b.valid;
      ne_ff <= both && a_ge;
      dd_ff <= both ? dd : '0;
      dh_ff <= both ? dh : '0;
      dm_ff <= both ? dm : '0;
      ds_ff <= both ? ds : '0;
      wd_ff <= lane_a.valid ? lane_a.weekday : '0;
   end

   assign strobe            = strobe_ff;
   assign first_valid       = fv_ff;
   assign other_valid       = ov_ff;
   assign first_not_earlier = ne_ff;
   assign diff_days         = dd_ff;
   assign diff_hours        = dh_ff;
   assign diff_minutes      = dm_ff;
   assign diff_seconds      = ds_ff;
   assign first_weekday     = wd_ff;

endmodule

### src/timestamp_difference_weekday_core.sv
// Top level: timestamp difference and weekday core, two lanes and a merge stage.
//
// Give two calendar timestamps with start; the core takes one pair every clock
// cycle and busy never rises. Each pair yields exactly one item on the rsp_
// ports, marked by rsp_strobe. A taken pair is registered first in the
// two lanes (range check and day number of each timestamp, done side by side
// with one constant multiply each) and then in the merge stage (ordering
// compare and the day, hour, minute and second subtraction with borrows).
// Nothing is stored between pairs and the receiver cannot stall, so results
// come out in the order the pairs went in, one per cycle at full rate.
// Leap years are every year divisible by four; years outside 1 to 9999 are
// invalid. With either timestamp invalid the difference fields read zero; the
// weekday (0 Monday to 6 Sunday) needs only the first timestamp to be valid.
module timestamp_difference_weekday_core
   import tsdw_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            start,
   output logic            busy,
   input  logic [4:0]      req_first_day,
   input  logic [3:0]      req_first_month,
   input  logic [13:0]     req_first_year,
   input  logic [4:0]      req_first_hour,
   input  logic [5:0]      req_first_minute,
   input  logic [5:0]      req_first_second,
   input  logic [4:0]      req_other_day,
   input  logic [3:0]      req_other_month,
   input  logic [13:0]     req_other_year,
   input  logic [4:0]      req_other_hour,
   input  logic [5:0]      req_other_minute,
   input  logic [5:0]      req_other_second,
   output logic            rsp_strobe,
   output logic            rsp_first_valid,
   output logic            rsp_other_valid,
   output logic            rsp_first_not_earlier,
   output logic [DayW-1:0] rsp_diff_days,
   output logic [4:0]      rsp_diff_hours,
   output logic [5:0]      rsp_diff_minutes,
   output logic [5:0]      rsp_diff_seconds,
   output logic [2:0]      rsp_first_weekday
);

   lane_out_type lane_first;
   lane_out_type lane_other;
   logic         lane_vld_ff;
   logic         lane_vld_in;

   // The pipeline never holds an item, so accept on every cycle.
   assign busy        = 1'b0;
   assign lane_vld_in = start && !busy;

   // Track which lane outputs carry a taken item.
   always_ff @(posedge clock) begin
      if (reset) begin
         lane_vld_ff <= 1'b0;
      end else begin
         lane_vld_ff <= lane_vld_in;
      end
   end

   // First timestamp lane; its weekday is the one reported.
   tsdw_lane u_lane_first (
      .clock    (clock),
      .day      (req_first_day),
      .month    (req_first_month),
      .year     (req_first_year),
      .hour     (req_first_hour),
      .minute   (req_first_minute),
      .second   (req_first_second),
      .lane_out (lane_first)
   );

   // Second timestamp lane.
   tsdw_lane u_lane_other (
      .clock    (clock),
      .day      (req_other_day),
      .month    (req_other_month),
      .year     (req_other_year),
      .hour     (req_other_hour),
      .minute   (req_other_minute),
      .second   (req_other_second),
      .lane_out (lane_other)
   );

   // Combine both lanes into the result item.
   tsdw_merge u_merge (
      .clock             (clock),
      .reset             (reset),
      .lane_vld          (lane_vld_ff),
      .lane_a            (lane_first),
      .lane_b            (lane_other),
      .strobe            (rsp_strobe),
      .first_valid       (rsp_first_valid),
      .other_valid       (rsp_other_valid),
      .first_not_earlier (rsp_first_not_earlier),
      .diff_days         (rsp_diff_days),
      .diff_hours        (rsp_diff_hours),
      .diff_minutes      (rsp_diff_minutes),
      .diff_seconds      (rsp_diff_seconds),
      .first_weekday     (rsp_first_weekday)
   );

   // Every taken item comes out with rsp_strobe set.
   a_latency: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |-> ##2 rsp_strobe)
      else $error("taken item did not produce a result two cycles later");

   // Borrow chain must leave remainders within their radix.
   a_radix: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> (rsp_diff_hours < 5'd24) && (rsp_diff_minutes < 6'd60)
                     && (rsp_diff_seconds < 6'd60))
      else $error("difference remainder out of range");

   // Ordering flag only for a pair of valid timestamps.
   a_order_valid: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_first_not_earlier) |-> (rsp_first_valid && rsp_other_valid))
      else $error("ordering flag set with an invalid timestamp");

   // Invalid first timestamp zeroes weekday and difference.
   a_first_invalid: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && !rsp_first_valid)
         |-> (rsp_first_weekday == 3'd0) && (rsp_diff_days == '0))
      else $error("invalid first timestamp left nonzero fields");

endmodule
